/* rtl/fdc_pkg.sv */
// Shared types, constants and the CRC byte update for the frame deframer.
`default_nettype none
package fdc_pkg;

  localparam int unsigned NumCodes  = 7;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 8;

  localparam logic [7:0]  SofByte  = 8'hAA;
  localparam logic [7:0]  EofByte  = 8'hBB;
  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'hA001;

  typedef logic [NumCodes-1:0][7:0] code_arr_t;

  localparam code_arr_t CodeReset = {8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1};

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_TYPE,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_CRC_HI,
    PH_CRC_LO,
    PH_END
  } phase_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_TYPE = 2'd1,
    ST_BAD_CRC  = 2'd2,
    ST_BAD_END  = 2'd3
  } status_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload;
    logic [7:0]  ftype;
    logic [15:0] length;
    status_e     status;
  } item_t;

  // CRC-16/MODBUS update by one byte, LSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* rtl/frame_deframer_crc16_core.sv */
// Top level of the byte-serial frame deframer with CRC-16/MODBUS check.
// Takes one received byte per clock unless stalled, and parses frames laid out
// as 0xAA, type, length (big-endian, 16 bit), payload, CRC (big-endian) and
// 0xBB. Bytes outside a frame are dropped until a 0xAA is seen. Each payload
// byte comes out as a word of kind 0 through the output buffer; the end byte,
// or a type matching none of the seven configured codes, gives one status word
// of kind 1 (0 ok, 1 bad type, 2 CRC mismatch, 3 bad end marker). The parser
// state and byte-wide CRC update are combinational; a two-entry output buffer
// holds finished words, stalling the input when full. Write type codes through
// the cfg port only while no frame is in progress; this is not enforced.
`default_nettype none
module frame_deframer_crc16_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fdc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fdc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          item_kind_o,
  output logic [7:0]                    payload_byte_o,
  output logic [7:0]                    frame_type_o,
  output logic [15:0]                   payload_length_o,
  output logic [1:0]                    frame_status_o
);
  import fdc_pkg::*;

  code_arr_t codes_q;
  logic      in_acc;
  logic      out_pop;
  logic      res_valid;
  item_t     res;
  item_t     head;
  logic      buf_full;

  // drop writes to indexes past the code list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q <= CodeReset;
    end else if (cfg_we_i && (32'(cfg_idx_i) < NumCodes)) begin
      codes_q[cfg_idx_i] <= cfg_data_i[7:0];
    end
  end

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_pop = out_valid_o && !out_stall_i;

  fdc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (in_acc),
    .byte_i      (rx_byte_i),
    .codes_i     (codes_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  fdc_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_acc && res_valid),
    .item_i  (res),
    .pop_i   (out_pop),
    .valid_o (out_valid_o),
    .full_o  (buf_full),
    .item_o  (head)
  );

  assign in_stall_o       = buf_full;
  assign item_kind_o      = head.kind;
  assign payload_byte_o   = head.payload;
  assign frame_type_o     = head.ftype;
  assign payload_length_o = head.length;
  assign frame_status_o   = head.status;

`ifndef SYNTHESIS
  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (item_kind_o == KIND_PAYLOAD)) |->
      ((frame_status_o == ST_OK) && (payload_length_o != 16'h0000)))
    else $error("payload word with status or zero length");

  a_bad_type_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (item_kind_o == KIND_STATUS) && (frame_status_o == ST_BAD_TYPE)) |->
      ((payload_length_o == 16'h0000) && (payload_byte_o == 8'h00)))
    else $error("bad-type status carries a length or payload");

  a_valid_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_pop))
    else $error("output word lost without being taken");

  a_accept_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res_valid) |-> !buf_full)
    else $error("word pushed into a full output buffer");
`endif

endmodule
`default_nettype wire

/* rtl/fdc_type_match.sv */
// Compare a type byte against the seven configured frame type codes.
`default_nettype none
module fdc_type_match (
  input  fdc_pkg::code_arr_t codes_i,
  input  logic [7:0]         type_i,
  output logic               known_o
);
  import fdc_pkg::*;

  always_comb begin
    known_o = 1'b0;
    for (int k = 0; k < NumCodes; k++) begin
      if (codes_i[k] == type_i) begin
        known_o = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/fdc_parser.sv */
// Frame parse state machine with running CRC; gives at most one word per accepted byte.
`default_nettype none
module fdc_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               acc_i,
  input  logic [7:0]         byte_i,
  input  fdc_pkg::code_arr_t codes_i,
  output logic               res_valid_o,
  output fdc_pkg::item_t     res_o
);
  import fdc_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] left_q, left_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] len_q, len_d;
  logic [15:0] rcrc_q, rcrc_d;
  logic [15:0] crc_next;
  logic        known;

  fdc_type_match u_match (
    .codes_i (codes_i),
    .type_i  (byte_i),
    .known_o (known)
  );

  // hunting seeds the CRC from its initial value
  assign crc_next = crc16_byte((phase_q == PH_HUNT) ? CrcInit : crc_q, byte_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      crc_q   <= CrcInit;
      left_q  <= '0;
      type_q  <= '0;
      len_q   <= '0;
      rcrc_q  <= '0;
    end else if (acc_i) begin
      phase_q <= phase_d;
      crc_q   <= crc_d;
      left_q  <= left_d;
      type_q  <= type_d;
      len_q   <= len_d;
      rcrc_q  <= rcrc_d;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    crc_d       = crc_q;
    left_d      = left_q;
    type_d      = type_q;
    len_d       = len_q;
    rcrc_d      = rcrc_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_PAYLOAD, payload: 8'h00, ftype: type_q,
                    length: len_q, status: ST_OK};
    unique case (phase_q)
      PH_HUNT: begin
        if (byte_i == SofByte) begin
          crc_d   = crc_next;
          phase_d = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_d = byte_i;
        if (!known) begin
          phase_d     = PH_HUNT;
          res_valid_o = 1'b1;
          res_o       = '{kind: KIND_STATUS, payload: 8'h00, ftype: byte_i,
                          length: 16'h0000, status: ST_BAD_TYPE};
        end else begin
          crc_d   = crc_next;
          phase_d = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        len_d   = {byte_i, 8'h00};
        crc_d   = crc_next;
        phase_d = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_d   = {len_q[15:8], byte_i};
        crc_d   = crc_next;
        left_d  = {len_q[15:8], byte_i};
        phase_d = ({len_q[15:8], byte_i} != 16'h0000) ? PH_PAYLOAD : PH_CRC_HI;
      end
      PH_PAYLOAD: begin
        crc_d       = crc_next;
        left_d      = left_q - 16'd1;
        if (left_q == 16'd1) begin
          phase_d = PH_CRC_HI;
        end
        res_valid_o = 1'b1;
        res_o.payload = byte_i;
      end
      PH_CRC_HI: begin
        rcrc_d  = {byte_i, 8'h00};
        phase_d = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        rcrc_d  = {rcrc_q[15:8], byte_i};
        phase_d = PH_END;
      end
      PH_END: begin
        phase_d      = PH_HUNT;
        res_valid_o  = 1'b1;
        res_o.kind   = KIND_STATUS;
        if (byte_i != EofByte) begin
          res_o.status = ST_BAD_END;
        end else if (rcrc_q != crc_q) begin
          res_o.status = ST_BAD_CRC;
        end else begin
          res_o.status = ST_OK;
        end
      end
      default: phase_d = PH_HUNT;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/fdc_out_buf.sv */
// Two-entry output register with skid stage between parser and consumer.
`default_nettype none
module fdc_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fdc_pkg::item_t item_i,
  input  logic           pop_i,
  output logic           valid_o,
  output logic           full_o,
  output fdc_pkg::item_t item_o
);
  import fdc_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  item_t      head_q, skid_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      // advance the skid word, or take the new word straight into the head
      if (cnt_q == 2'd2) begin
        head_q <= skid_q;
        if (push_i) begin
          skid_q <= item_i;
        end
      end else if (push_i) begin
        head_q <= item_i;
      end
    end else if (push_i) begin
      if (cnt_q == 2'd0) begin
        head_q <= item_i;
      end else begin
        skid_q <= item_i;
      end
    end
  end

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign item_o  = head_q;

endmodule
`default_nettype wire

/* dv/frame_deframer_crc16_core_tb.sv */
// Self-checking testbench for the frame deframer: directed frames, then random traffic.
`timescale 1ns / 100ps
module frame_deframer_crc16_core_tb;
  import fdc_pkg::*;

  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PhaseItems   = 360;
  localparam int unsigned ReportMax    = 10;
  localparam logic [CfgIdxW-1:0] NoSuchIdx = CfgIdxW'(NumCodes);

  typedef enum logic [1:0] {SRC_LIT, SRC_CRC_HI, SRC_CRC_LO, SRC_CRC_BAD} row_src_e;
  typedef enum logic [2:0] {FR_GOOD, FR_BAD_TYPE, FR_BAD_CRC, FR_BAD_END, FR_CUT} frame_mode_e;

  typedef struct packed {
    row_src_e src;
    logic [7:0] val;
    bit typed;
    item_t want;
  } plan_row_t;

  localparam item_t NoWord = '0;

  // hunting, resync on 0xAA, bad end over bad CRC, good frame with extreme payload,
  // zero length with a wrong CRC
  localparam plan_row_t Plan [26] = '{
    '{SRC_LIT, 8'h00, 1'b0, NoWord},
    '{SRC_LIT, 8'hAA, 1'b0, NoWord},
    '{SRC_LIT, 8'hAA, 1'b1, '{KIND_STATUS, 8'h00, 8'hAA, 16'h0000, ST_BAD_TYPE}},
    '{SRC_LIT, 8'hAA, 1'b0, NoWord},
    '{SRC_LIT, 8'h03, 1'b0, NoWord},
    '{SRC_LIT, 8'h00, 1'b0, NoWord},
    '{SRC_LIT, 8'h00, 1'b0, NoWord},
    '{SRC_LIT, 8'h12, 1'b0, NoWord},
    '{SRC_LIT, 8'h34, 1'b0, NoWord},
    '{SRC_LIT, 8'hAA, 1'b1, '{KIND_STATUS, 8'h00, 8'h03, 16'h0000, ST_BAD_END}},
    '{SRC_LIT, 8'hAA, 1'b0, NoWord},
    '{SRC_LIT, 8'h01, 1'b0, NoWord},
    '{SRC_LIT, 8'h00, 1'b0, NoWord},
    '{SRC_LIT, 8'h02, 1'b0, NoWord},
    '{SRC_LIT, 8'h00, 1'b0, NoWord},
    '{SRC_LIT, 8'hFF, 1'b0, NoWord},
    '{SRC_CRC_HI, 8'h00, 1'b0, NoWord},
    '{SRC_CRC_LO, 8'h00, 1'b0, NoWord},
    '{SRC_LIT, 8'hBB, 1'b1, '{KIND_STATUS, 8'h00, 8'h01, 16'h0002, ST_OK}},
    '{SRC_LIT, 8'hAA, 1'b0, NoWord},
    '{SRC_LIT, 8'h07, 1'b0, NoWord},
    '{SRC_LIT, 8'h00, 1'b0, NoWord},
    '{SRC_LIT, 8'h00, 1'b0, NoWord},
    '{SRC_CRC_HI, 8'h00, 1'b0, NoWord},
    '{SRC_CRC_BAD, 8'h00, 1'b0, NoWord},
    '{SRC_LIT, 8'hBB, 1'b1, '{KIND_STATUS, 8'h00, 8'h07, 16'h0000, ST_BAD_CRC}}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [7:0] rx_byte_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic item_kind_o;
  logic [7:0] payload_byte_o;
  logic [7:0] frame_type_o;
  logic [15:0] payload_length_o;
  logic [1:0] frame_status_o;

  frame_deframer_crc16_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .item_kind_o     (item_kind_o),
    .payload_byte_o  (payload_byte_o),
    .frame_type_o    (frame_type_o),
    .payload_length_o(payload_length_o),
    .frame_status_o  (frame_status_o)
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  phase_e      frm_phase;
  logic [15:0] crc_acc;
  logic [15:0] left_cnt;
  logic [7:0]  held_type_q;
  logic [15:0] held_len_q;
  logic [15:0] rx_crc_q;
  code_arr_t   type_tab;

  item_t       pending_words [$];
  int unsigned fed_items = 0;
  int unsigned words_seen = 0;
  int unsigned fails = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned stall_run = 0;

  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic fb;
    r = acc;
    // bit-serial form: data enters LSB first
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r = r >> 1;
      if (fb) r = r ^ CrcPoly;
    end
    return r;
  endfunction

  function automatic bit code_hit(input logic [7:0] t);
    for (int i = 0; i < NumCodes; i++) begin
      if (type_tab[i] == t) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic item_t make_word(input kind_e k, input logic [7:0] pb,
                                      input logic [15:0] len, input status_e st);
    item_t w;
    w.kind = k;
    w.payload = pb;
    w.ftype = held_type_q;
    w.length = len;
    w.status = st;
    return w;
  endfunction

  // Advance the parser by one byte; return 1 when the byte yields a word.
  function automatic bit parse_byte(input logic [7:0] b, output item_t w);
    w = NoWord;
    if (frm_phase != PH_HUNT || b == SofByte) fed_items++;
    case (frm_phase)
      PH_HUNT: begin
        if (b == SofByte) begin
          crc_acc = crc_step(CrcInit, b);
          frm_phase = PH_TYPE;
        end
      end
      PH_TYPE: begin
        held_type_q = b;
        if (!code_hit(b)) begin
          frm_phase = PH_HUNT;
          w = make_word(KIND_STATUS, 8'h00, 16'h0000, ST_BAD_TYPE);
          return 1'b1;
        end
        crc_acc = crc_step(crc_acc, b);
        frm_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        held_len_q = {b, 8'h00};
        crc_acc = crc_step(crc_acc, b);
        frm_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        held_len_q[7:0] = b;
        crc_acc = crc_step(crc_acc, b);
        left_cnt = held_len_q;
        frm_phase = (left_cnt != 0) ? PH_PAYLOAD : PH_CRC_HI;
      end
      PH_PAYLOAD: begin
        crc_acc = crc_step(crc_acc, b);
        left_cnt = left_cnt - 16'd1;
        if (left_cnt == 0) frm_phase = PH_CRC_HI;
        w = make_word(KIND_PAYLOAD, b, held_len_q, ST_OK);
        return 1'b1;
      end
      PH_CRC_HI: begin
        rx_crc_q = {b, 8'h00};
        frm_phase = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        rx_crc_q[7:0] = b;
        frm_phase = PH_END;
      end
      default: begin
        frm_phase = PH_HUNT;
        if (b != EofByte) w = make_word(KIND_STATUS, 8'h00, held_len_q, ST_BAD_END);
        else if (rx_crc_q != crc_acc) w = make_word(KIND_STATUS, 8'h00, held_len_q, ST_BAD_CRC);
        else w = make_word(KIND_STATUS, 8'h00, held_len_q, ST_OK);
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] frame_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'd0;
    if (r < 85) return 16'($urandom_range(1, 12));
    return 16'($urandom_range(13, 64));
  endfunction

  // Entered and left on a falling edge; valid stays high for a following word.
  task automatic push_byte(input logic [7:0] b, input bit typed, input item_t want);
    item_t word;
    bit has_word;
    int unsigned gap;
    gap = calm ? 0 : (($urandom_range(0, 99) < 55) ? 0 : idle_len());
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    has_word = parse_byte(b, word);
    if (typed) word = want;
    if (has_word || typed) pending_words.push_back(word);
    @(negedge clk_i);
  endtask

  // Keep stray length fields small so a desynchronised parser recovers quickly.
  task automatic push_loose(input logic [7:0] b);
    if (frm_phase == PH_LEN_HI) b[7:1] = '0;
    push_byte(b, 1'b0, NoWord);
  endtask

  task automatic flush_frame();
    while (frm_phase != PH_HUNT) push_loose(8'($urandom_range(0, 255)));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic program_codes(input code_arr_t v);
    for (int i = 0; i < NumCodes; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= CfgIdxW'(i);
      cfg_data_i <= v[i];
      type_tab[i] = v[i];
      @(negedge clk_i);
    end
    // a write to an unused index must leave the table alone
    cfg_idx_i <= NoSuchIdx;
    cfg_data_i <= 8'($urandom_range(0, 255));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_frame(input frame_mode_e mode, input logic [15:0] len);
    logic [7:0] bytes_q [$];
    logic [15:0] c;
    logic [7:0] t;
    logic [7:0] e;
    int unsigned n;
    flush_frame();
    if (mode == FR_BAD_TYPE) begin
      do t = 8'($urandom_range(0, 255)); while (code_hit(t));
      push_byte(SofByte, 1'b0, NoWord);
      push_byte(t, 1'b0, NoWord);
      return;
    end
    t = type_tab[$urandom_range(0, NumCodes - 1)];
    bytes_q = '{SofByte, t, len[15:8], len[7:0]};
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 5))
        0: bytes_q.push_back(8'h00);
        1: bytes_q.push_back(8'hFF);
        default: bytes_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    c = CrcInit;
    foreach (bytes_q[i]) c = crc_step(c, bytes_q[i]);
    if (mode == FR_BAD_CRC) c = c ^ (16'h0001 << $urandom_range(0, 15));
    e = EofByte;
    if (mode == FR_BAD_END) begin
      do e = 8'($urandom_range(0, 255)); while (e == EofByte);
    end
    bytes_q.push_back(c[15:8]);
    bytes_q.push_back(c[7:0]);
    bytes_q.push_back(e);
    n = (mode == FR_CUT) ? $urandom_range(1, bytes_q.size() - 1) : bytes_q.size();
    for (int i = 0; i < n; i++) push_byte(bytes_q[i], 1'b0, NoWord);
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned goal;
    int unsigned pick;
    int unsigned burst;
    goal = fed_items + count;
    while (fed_items < goal) begin
      calm = ($urandom_range(0, 7) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) send_frame(FR_GOOD, frame_len());
      else if (pick < 76) send_frame(FR_BAD_TYPE, 16'd0);
      else if (pick < 82) send_frame(FR_BAD_CRC, frame_len());
      else if (pick < 88) send_frame(FR_BAD_END, frame_len());
      else if (pick < 94) send_frame(FR_CUT, frame_len());
      else begin
        burst = $urandom_range(1, 6);
        repeat (burst) begin
          push_loose(($urandom_range(0, 3) == 0) ? SofByte : 8'($urandom_range(0, 255)));
        end
      end
      if ($urandom_range(0, 49) == 0) drain();
    end
    calm = 1'b0;
    flush_frame();
    drain();
  endtask

  // receiver back-pressure
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      out_stall_i <= 1'b1;
      repeat (HoldCycles) @(negedge clk_i);
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else if (stall_run != 0) begin
      out_stall_i <= 1'b1;
      stall_run--;
    end else begin
      out_stall_i <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_run = idle_len();
    end
  end

  task automatic note_fail(input string msg);
    fails++;
    if (fails <= ReportMax) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk_i) begin : check_words
    item_t got;
    item_t exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {item_kind_o, payload_byte_o, frame_type_o, payload_length_o, frame_status_o};
      words_seen++;
      if (pending_words.size() == 0) begin
        note_fail($sformatf("unexpected word kind %0d byte %h type %h len %h status %0d",
                            got.kind, got.payload, got.ftype, got.length, got.status));
      end else begin
        exp = pending_words.pop_front();
        if (got.kind !== exp.kind || got.payload !== exp.payload ||
            got.ftype !== exp.ftype || got.length !== exp.length ||
            got.status !== exp.status) begin
          note_fail($sformatf({"word mismatch: exp kind %0d byte %h type %h len %h status %0d,",
                               " got kind %0d byte %h type %h len %h status %0d"},
                              exp.kind, exp.payload, exp.ftype, exp.length, exp.status,
                              got.kind, got.payload, got.ftype, got.length, got.status));
        end else if (got.kind == KIND_STATUS) begin
          status_seen[got.status]++;
        end
      end
    end
  end

  initial begin
    #(40_000_000);
    $display("frame_deframer_crc16_core_tb failed");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] b;
    code_arr_t codes;
    frm_phase = PH_HUNT;
    crc_acc = CrcInit;
    left_cnt = '0;
    held_type_q = '0;
    held_len_q = '0;
    rx_crc_q = '0;
    type_tab = CodeReset;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (Plan[i]) begin
      case (Plan[i].src)
        SRC_CRC_HI: b = crc_acc[15:8];
        SRC_CRC_LO: b = crc_acc[7:0];
        SRC_CRC_BAD: b = ~crc_acc[7:0];
        default: b = Plan[i].val;
      endcase
      push_byte(b, Plan[i].typed, Plan[i].want);
    end
    drain();

    // hold the receiver off while a long frame streams in, so the input backs up
    hold_req = 1'b1;
    calm = 1'b1;
    send_frame(FR_GOOD, 16'd40);
    calm = 1'b0;
    random_phase(PhaseItems);

    program_codes({8'h01, 8'h7F, 8'h80, 8'hBB, 8'hAA, 8'hFF, 8'h00});
    random_phase(PhaseItems);

    for (int i = 0; i < NumCodes; i++) codes[i] = 8'($urandom_range(0, 255));
    program_codes(codes);
    random_phase(PhaseItems);

    program_codes({NumCodes{8'hFF}});
    // one long frame, streamed without gaps
    calm = 1'b1;
    send_frame(FR_GOOD, 16'd64);
    calm = 1'b0;
    random_phase(PhaseItems);

    $display("covered %0d parsed bytes and %0d output words over four type-code settings",
             fed_items, words_seen);
    $display("frame endings: ok %0d, bad type %0d, crc mismatch %0d, bad end %0d",
             status_seen[ST_OK], status_seen[ST_BAD_TYPE], status_seen[ST_BAD_CRC],
             status_seen[ST_BAD_END]);
    if (fails == 0 && pending_words.size() == 0) begin
      $display("frame_deframer_crc16_core_tb passed");
    end else begin
      $display("frame_deframer_crc16_core_tb failed");
    end
    $finish;
  end

endmodule
